// ----- hdl/rpn_pkg.sv -----
// Shared constants, codes and controller/datapath types of the RPN evaluator.
`timescale 1ns / 1ps
package rpn_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DATA_W      = 8;
  localparam int DIV_STEPS   = DATA_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_t;

  typedef struct packed {
    logic    load_ch;
    logic    push;
    logic    rd_top;
    logic    rd_second;
    logic    latch_b;
    logic    write_res;
    logic    div_start;
    logic    set_err;
    status_t err_code;
    logic    set_eq;
    logic    clear;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_eq;
    logic is_op;
    logic is_div;
    logic cnt_zero;
    logic cnt_lt2;
    logic cnt_full;
    logic b_zero;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/rpn_char_if.sv -----
// Input channel carrying one ASCII character per item.
`timescale 1ns / 1ps
interface rpn_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

// ----- hdl/rpn_res_if.sv -----
// Result channel carrying an expression value and a status code per item.
`timescale 1ns / 1ps
interface rpn_res_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] value;
  rpn_pkg::status_t  status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

// ----- hdl/rpn_div.sv -----
// Bit-serial signed divider truncating toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps
module rpn_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rpn_pkg::DATA_W-1:0]   dividend,
  input  logic [rpn_pkg::DATA_W-1:0]   divisor,
  output logic                         done,
  output logic [rpn_pkg::DATA_W-1:0]   quotient
);
  import rpn_pkg::*;

  logic [DATA_W:0]    rem;
  logic [DATA_W-1:0]  quo;
  logic [DATA_W-1:0]  dsr;
  logic               neg;
  logic [DIV_CNT_W-1:0] steps;
  logic               busy;

  logic [DATA_W:0]    rem_sh;
  logic [DATA_W+1:0]  trial;
  logic [DATA_W-1:0]  a_mag;
  logic [DATA_W-1:0]  b_mag;

  always_comb begin
    a_mag  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
    b_mag  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
    rem_sh = {rem[DATA_W-1:0], quo[DATA_W-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= a_mag;
      dsr <= b_mag;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      if (!trial[DATA_W+1]) begin
        rem <= trial[DATA_W:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

// ----- hdl/rpn_dp.sv -----
// Datapath: stack memory, depth counter, operand registers, ALU and output register.
`timescale 1ns / 1ps
module rpn_dp (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      ch,
  input  rpn_pkg::cmd_t   cmd,
  output rpn_pkg::stat_t  stat,
  rpn_res_if.source       results
);
  import rpn_pkg::*;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [7:0]        ch_reg;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] b_reg;
  logic [DATA_W-1:0] res_value;
  status_t           res_status;
  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  status_t           out_status;

  logic [ADDR_W-1:0]   raddr;
  logic [ADDR_W-1:0]   top_addr;
  logic [ADDR_W-1:0]   second_addr;
  logic [ADDR_W-1:0]   push_addr;
  logic [DATA_W-1:0]   alu_res;
  logic [DATA_W-1:0]   wdata;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]   div_q;
  logic                div_done;

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rdata),
    .divisor  (b_reg),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    top_addr    = ADDR_W'(cnt - CNT_W'(1));
    second_addr = ADDR_W'(cnt - CNT_W'(2));
    push_addr   = ADDR_W'(cnt);
    raddr       = cmd.rd_top ? top_addr : second_addr;
    prod        = rdata * b_reg;
    case (ch_reg)
      CH_ADD:  alu_res = rdata + b_reg;
      CH_SUB:  alu_res = rdata - b_reg;
      CH_MUL:  alu_res = prod[DATA_W-1:0];
      default: alu_res = div_q;
    endcase
    wdata = cmd.push ? (ch_reg - CH_ZERO) : alu_res;
  end

  always_comb begin
    stat.is_digit = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    stat.is_eq    = (ch_reg == CH_EQ);
    stat.is_op    = (ch_reg == CH_ADD) || (ch_reg == CH_SUB) ||
                    (ch_reg == CH_MUL) || (ch_reg == CH_DIV);
    stat.is_div   = (ch_reg == CH_DIV);
    stat.cnt_zero = (cnt == '0);
    stat.cnt_lt2  = (cnt < CNT_W'(2));
    stat.cnt_full = (cnt >= CNT_W'(STACK_DEPTH));
    stat.b_zero   = (b_reg == '0);
    stat.div_done = div_done;
    stat.out_free = !out_valid || results.ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[push_addr] <= wdata;
    end else if (cmd.write_res) begin
      mem[second_addr] <= wdata;
    end
    if (cmd.rd_top || cmd.rd_second) begin
      rdata <= mem[raddr];
    end
    if (cmd.load_ch) begin
      ch_reg <= ch;
    end
    if (cmd.latch_b) begin
      b_reg <= rdata;
    end
    if (cmd.set_err) begin
      res_value  <= '0;
      res_status <= cmd.err_code;
    end else if (cmd.set_eq) begin
      res_value  <= rdata;
      res_status <= ST_OK;
    end
    if (cmd.emit) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        cnt <= '0;
      end else if (cmd.push) begin
        cnt <= cnt + 1'b1;
      end else if (cmd.write_res) begin
        cnt <= cnt - 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign results.valid  = out_valid;
  assign results.value  = out_value;
  assign results.status = out_status;

endmodule

// ----- hdl/rpn_ctrl.sv -----
// Controller state machine sequencing each character through the datapath.
`timescale 1ns / 1ps
module rpn_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rpn_pkg::stat_t  stat,
  output rpn_pkg::cmd_t   cmd
);
  import rpn_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_RD_B   = 7'b0000100,
    S_EXEC   = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_EQ     = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_ch = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_digit) begin
          if (stat.cnt_full) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_OVERFLOW;
            cmd.clear    = 1'b1;
            state_next   = S_EMIT;
          end else begin
            cmd.push   = 1'b1;
            state_next = S_IDLE;
          end
        end else if (stat.is_eq) begin
          if (stat.cnt_zero) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_UNDERFLOW;
            cmd.clear    = 1'b1;
            state_next   = S_EMIT;
          end else begin
            cmd.rd_top = 1'b1;
            state_next = S_EQ;
          end
        end else if (stat.is_op) begin
          if (stat.cnt_lt2) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_UNDERFLOW;
            cmd.clear    = 1'b1;
            state_next   = S_EMIT;
          end else begin
            cmd.rd_top = 1'b1;
            state_next = S_RD_B;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RD_B: begin
        cmd.latch_b   = 1'b1;
        cmd.rd_second = 1'b1;
        state_next    = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_div) begin
          if (stat.b_zero) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_DIVZERO;
            cmd.clear    = 1'b1;
            state_next   = S_EMIT;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end else begin
          cmd.write_res = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.write_res = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_EQ: begin
        cmd.set_eq = 1'b1;
        cmd.clear  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/rpn_stack_evaluator_core.sv -----
// Top level of the reverse Polish expression evaluator.
//
// The chars channel takes one ASCII character per item. Digits push their
// value on a stack of signed 8-bit entries, + - * / combine the top two
// entries, and = sends the top entry on the results channel with status
// ok and empties the stack. Overflow, underflow and division by zero send
// a zero value with an error status and empty the stack. Other characters
// are dropped without a result.
// Digits and ignored characters end in S_DECODE; + - * go on through
// S_RD_B and S_EXEC, = through S_EQ to the output register, and / also
// waits in S_DIV for the bit-serial divider, one quotient bit per cycle.
// The stack memory has one read port, so an operator reads its top entry
// in S_DECODE, the second in S_RD_B. One item is processed at a time.
// Reset empties the stack and drops any result held in the output
// register; no clearing pass is needed. While the receiver stalls, a held
// result waits in the output register and the block keeps accepting
// characters until it has a second result to deliver.
`timescale 1ns / 1ps
module rpn_stack_evaluator_core (
  input  logic      clk,
  input  logic      rst,
  rpn_char_if.sink  chars,
  rpn_res_if.source results
);
  import rpn_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chars.valid),
    .in_ready (chars.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpn_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .ch      (chars.ch),
    .cmd     (cmd),
    .stat    (stat),
    .results (results)
  );

endmodule

// ----- hdl/rpn_chk.sv -----
// Port-level checker for the RPN evaluator and its bind to the top level.
`timescale 1ns / 1ps
module rpn_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_value,
  input logic [1:0] out_status
);
  import rpn_pkg::*;

  a_reset_no_result: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_error_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != ST_OK) |-> out_value == 8'h00)
    else $error("error item carries a nonzero value");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready in the cycle after an accepted item");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind rpn_stack_evaluator_core rpn_chk u_rpn_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (chars.valid),
  .in_ready   (chars.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_value  (results.value),
  .out_status (results.status)
);

// ----- tb/rpn_stack_evaluator_core_tb.sv -----
// Self-checking testbench of the RPN evaluator, with a shadow stack that predicts each result.
`timescale 1ns / 1ps
module rpn_stack_evaluator_core_tb;
  import rpn_pkg::*;

  localparam int ITEM_TARGET   = 1650;
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic signed [7:0] value;
    status_t           status;
  } rpn_result_t;

  class rpn_eval_shadow;
    logic [7:0]  stack_mem [STACK_DEPTH];
    int unsigned depth;
    rpn_result_t result_q[$];
    int unsigned errors;

    function new();
      depth  = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return result_q.size();
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void queue_result(logic signed [7:0] v, status_t s);
      rpn_result_t item;
      item.value  = v;
      item.status = s;
      result_q.push_back(item);
    endfunction

    function void apply_char(logic [7:0] c);
      int a;
      int b;
      int r;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (depth >= STACK_DEPTH) begin
          depth = 0;
          queue_result(8'sd0, ST_OVERFLOW);
        end else begin
          stack_mem[depth] = c - CH_ZERO;
          depth++;
        end
      end else if (c == CH_EQ) begin
        if (depth == 0) begin
          queue_result(8'sd0, ST_UNDERFLOW);
        end else begin
          queue_result(stack_mem[depth - 1], ST_OK);
          depth = 0;
        end
      end else if (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV) begin
        if (depth < 2) begin
          depth = 0;
          queue_result(8'sd0, ST_UNDERFLOW);
        end else begin
          b = $signed(stack_mem[depth - 1]);
          a = $signed(stack_mem[depth - 2]);
          if (c == CH_DIV && b == 0) begin
            depth = 0;
            queue_result(8'sd0, ST_DIVZERO);
          end else begin
            case (c)
              CH_ADD: r = a + b;
              CH_SUB: r = a - b;
              CH_MUL: r = a * b;
              default: r = a / b;
            endcase
            depth--;
            stack_mem[depth - 1] = r[7:0];
          end
        end
      end
    endfunction

    task check_result(logic signed [7:0] v, status_t s);
      rpn_result_t want;
      if (result_q.size() == 0) begin
        report($sformatf("result with nothing pending: value %0d status %0d", v, s));
      end else begin
        want = result_q.pop_front();
        if (v !== want.value)
          report($sformatf("value %0d, predicted %0d", v, want.value));
        if (s !== want.status)
          report($sformatf("status %0d, predicted %0d", s, want.status));
      end
    endtask
  endclass

  logic           clk;
  logic           rst;
  int unsigned    counted_items = 0;
  int unsigned    burst_left = 1;
  logic           hold_trigger = 1'b0;
  rpn_eval_shadow shadow = new();

  rpn_char_if chars_if ();
  rpn_res_if  res_if ();

  rpn_stack_evaluator_core DUT (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit is_active(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_EQ || c == CH_ADD ||
           c == CH_SUB || c == CH_MUL || c == CH_DIV;
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0: return CH_ADD;
      1: return CH_SUB;
      2: return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  task automatic send_char(logic [7:0] c);
    chars_if.valid <= 1'b1;
    chars_if.ch    <= c;
    do @(posedge clk); while (chars_if.ready !== 1'b1);
    shadow.apply_char(c);
    if (is_active(c)) counted_items++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      chars_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic drain_results();
    chars_if.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_expr();
    int unsigned d;
    int unsigned len;
    int unsigned k;
    bit          broken;
    d      = 0;
    len    = $urandom_range(1, 12);
    broken = ($urandom_range(0, 7) == 0);
    for (k = 0; k < len; k++) begin
      if (d >= 2 && $urandom_range(0, 2) != 0) begin
        send_char(pick_op());
        d--;
      end else begin
        send_char(CH_ZERO + 8'($urandom_range(0, 9)));
        d++;
      end
      if ($urandom_range(0, 15) == 0) send_char(8'($urandom_range(0, 255)));
    end
    if (broken) begin
      repeat ($urandom_range(0, 3)) send_char(pick_op());
    end else begin
      while (d > 1) begin
        send_char(pick_op());
        d--;
      end
    end
    send_char(CH_EQ);
  endtask

  task automatic send_deep(int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) send_char(CH_ZERO + 8'($urandom_range(1, 9)));
    for (k = 0; k < $urandom_range(0, 4); k++) send_char(pick_op());
    send_char(CH_EQ);
  endtask

  initial begin
    int unsigned pick;
    bit          hold_asked;
    bit          drain_asked;
    hold_asked  = 1'b0;
    drain_asked = 1'b0;
    chars_if.valid <= 1'b0;
    chars_if.ch    <= 8'h00;
    rst            <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("=+5+80/");
    send_char(8'h20);
    send_text("99*9*=");
    send_char(8'hFF);
    send_char(8'h80);
    send_text("08-44**01-/=");
    send_char(8'h00);
    send_char(8'h7F);
    drain_results();

    send_deep(STACK_DEPTH);
    send_deep(STACK_DEPTH + 2);

    while (counted_items < ITEM_TARGET) begin
      if (!hold_asked && counted_items > 600) begin
        hold_asked = 1'b1;
        hold_trigger <= 1'b1;
      end
      if (!drain_asked && counted_items > 1100) begin
        drain_asked = 1'b1;
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_deep($urandom_range(100, STACK_DEPTH + 3));
      end else if (pick < 6) begin
        repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
      end else if (pick < 8) begin
        drain_results();
      end else begin
        send_expr();
      end
    end

    drain_results();
    if (shadow.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_served;
    mode        = 0;
    mode_left   = 0;
    stall_left  = 0;
    hold_left   = 0;
    hold_served = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
        shadow.check_result(res_if.value, res_if.status);
      if (hold_trigger && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          2: res_if.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              res_if.ready <= 1'b0;
            end else begin
              res_if.ready <= 1'b1;
              if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 30);
            end
          end
        endcase
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((chars_if.valid === 1'b1 && chars_if.ready === 1'b1) ||
          (res_if.valid === 1'b1 && res_if.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
